// ----- hw/rtl/na2f_pkg.sv -----
// ----------------------------------------------------------------------------
// na2f_pkg: shared definitions for the navigation ASCII to fixed-point block
// Controller states, command and status structs, character codes and
// result status codes.
// ----------------------------------------------------------------------------
package na2f_pkg;

	// Default width of the signed fixed-point result
	localparam int unsigned VALUE_BITS_DEF = 32;

	// Width of the fractional-digits register
	localparam int unsigned FRAC_W = 4;

	// Character codes
	localparam logic [7:0] CH_UP_N = 8'h4E;
	localparam logic [7:0] CH_LO_N = 8'h6E;
	localparam logic [7:0] CH_UP_E = 8'h45;
	localparam logic [7:0] CH_UP_S = 8'h53;
	localparam logic [7:0] CH_UP_W = 8'h57;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	// Result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NAN = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LEAD,
		S_AFTER_PFX,
		S_NANPOS,
		S_NA1,
		S_NA2,
		S_DIGITS,
		S_SCALE,
		S_EMIT_NUM,
		S_EMIT_NAN
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;     // new field starts with this character
		logic neg;       // sign prefix is negative
		logic digit;     // accumulate a decimal digit
		logic point;     // decimal point seen
		logic finish;    // field ends: capture scaling count
		logic scale_en;  // run one scaling step
		logic emit_num;  // load numeric result
		logic emit_nan;  // load not-a-number result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scale_done;
		logic out_free;
	} sts_t;

	// White space: tab to carriage return, and space
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ----- hw/rtl/na2f_if.sv -----
// ----------------------------------------------------------------------------
// na2f_if: valid/ready channels of the converter
// Character channel in, result channel out.
// ----------------------------------------------------------------------------
interface na2f_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface na2f_res_if #(
	parameter int unsigned VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [1:0]                   status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ----- hw/rtl/na2f_ctrl.sv -----
// ----------------------------------------------------------------------------
// na2f_ctrl: field parser and sequencer
// Walks the prefix, NAN and digit phases one character per cycle, then, for a
// number, runs the scaling steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module na2f_ctrl
	import na2f_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] ch,
	input  logic       start_req,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	state_t ph;
	logic   txn;
	logic   live;

	// Character classes
	logic c_ws, c_dig, c_pt, c_ne, c_sw, c_minus, c_plus, c_n, c_a;

	assign c_ws    = is_ws(ch);
	assign c_dig   = is_digit(ch);
	assign c_pt    = (ch == CH_POINT);
	assign c_ne    = (ch == CH_UP_N) || (ch == CH_UP_E);
	assign c_sw    = (ch == CH_UP_S) || (ch == CH_UP_W);
	assign c_minus = (ch == CH_MINUS);
	assign c_plus  = (ch == CH_PLUS);
	assign c_n     = (ch == CH_UP_N) || (ch == CH_LO_N);
	assign c_a     = (ch == CH_UP_A) || (ch == CH_LO_A);

	// Characters are taken in every parsing state
	assign in_ready = (state_q != S_SCALE) && (state_q != S_EMIT_NUM) &&
		(state_q != S_EMIT_NAN);
	assign txn  = in_valid && in_ready;
	// A start request restarts the field from the leading phase
	assign ph   = start_req ? S_LEAD : state_q;
	assign live = txn && (start_req || (state_q != S_IDLE));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SCALE: begin
				if (sts.scale_done) begin
					state_d = S_EMIT_NUM;
				end
			end
			S_EMIT_NUM, S_EMIT_NAN: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				if (live) begin
					case (ph)
						S_LEAD: begin
							if (c_ws) begin
								state_d = S_LEAD;
							end else if (c_ne || c_sw) begin
								state_d = S_AFTER_PFX;
							end else if (c_minus || c_plus) begin
								state_d = S_NANPOS;
							end else if (c_n) begin
								state_d = S_NA1;
							end else begin
								state_d = (c_dig || c_pt) ? S_DIGITS : S_SCALE;
							end
						end
						S_AFTER_PFX: begin
							if (c_ws) begin
								state_d = S_AFTER_PFX;
							end else if (c_n) begin
								state_d = S_NA1;
							end else begin
								state_d = (c_dig || c_pt) ? S_DIGITS : S_SCALE;
							end
						end
						S_NANPOS: begin
							if (c_n) begin
								state_d = S_NA1;
							end else begin
								state_d = (c_dig || c_pt) ? S_DIGITS : S_SCALE;
							end
						end
						S_NA1: begin
							state_d = c_a ? S_NA2 : S_SCALE;
						end
						S_NA2: begin
							state_d = c_n ? S_EMIT_NAN : S_SCALE;
						end
						S_DIGITS: begin
							state_d = (c_dig || c_pt) ? S_DIGITS : S_SCALE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_SCALE: begin
				cmd.scale_en = 1'b1;
			end
			S_EMIT_NUM: begin
				cmd.emit_num = sts.out_free;
			end
			S_EMIT_NAN: begin
				cmd.emit_nan = sts.out_free;
			end
			default: begin
				if (live) begin
					cmd.clear = start_req;
					case (ph)
						S_LEAD: begin
							if (c_sw || c_minus) begin
								cmd.neg = 1'b1;
							end else if (!(c_ws || c_ne || c_plus || c_n)) begin
								cmd.digit  = c_dig;
								cmd.point  = c_pt;
								cmd.finish = !(c_dig || c_pt);
							end
						end
						S_AFTER_PFX: begin
							if (!(c_ws || c_n)) begin
								cmd.digit  = c_dig;
								cmd.point  = c_pt;
								cmd.finish = !(c_dig || c_pt);
							end
						end
						S_NANPOS: begin
							if (!c_n) begin
								cmd.digit  = c_dig;
								cmd.point  = c_pt;
								cmd.finish = !(c_dig || c_pt);
							end
						end
						S_NA1: begin
							cmd.finish = !c_a;
						end
						S_NA2: begin
							cmd.finish = !c_n;
						end
						S_DIGITS: begin
							cmd.digit  = c_dig;
							cmd.point  = c_pt;
							cmd.finish = !(c_dig || c_pt);
						end
						default: begin
							cmd.clear = 1'b0;
						end
					endcase
				end
			end
		endcase
	end

endmodule

// ----- hw/rtl/na2f_dp.sv -----
// ----------------------------------------------------------------------------
// na2f_dp: magnitude accumulator, scaler and result register
// Times-ten with saturation, divide by ten eight quotient bits per cycle,
// sign applied on the way into the result register.
// ----------------------------------------------------------------------------
module na2f_dp
	import na2f_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [FRAC_W-1:0]            frac_digits,
	input  logic [7:0]                   ch,
	input  logic                         res_ready,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	output logic                         res_valid,
	output logic signed [VALUE_BITS-1:0] res_value,
	output logic [1:0]                   res_status
);

	localparam int unsigned MAGW       = VALUE_BITS - 1;
	// Quotient bits produced per divider cycle
	localparam int unsigned DIV_STEP   = 8;
	localparam int unsigned DIV_CHUNKS = (MAGW + DIV_STEP - 1) / DIV_STEP;
	localparam int unsigned DIVW       = DIV_CHUNKS * DIV_STEP;
	localparam int unsigned DCW        = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;
	localparam logic [MAGW-1:0] MAG_MAX = '1;

	// Field state
	logic [MAGW-1:0]    mag_q;
	logic               neg_q;
	logic               pt_q;
	logic [4:0]         fc_q;
	logic               ovf_q;
	// Scaling state: signed count of pending steps, divider
	logic signed [5:0]  adj_q;
	logic               div_act_q;
	logic [DCW-1:0]     dcnt_q;
	logic [3:0]         rem_q;
	logic [DIVW-1:0]    div_q;
	// Result register
	logic                         out_valid_q;
	logic signed [VALUE_BITS-1:0] out_value_q;
	logic [1:0]                   out_status_q;

	logic [MAGW-1:0]   mag_b;
	logic              neg_b, pt_b, ovf_b;
	logic [4:0]        fc_b;
	logic [4:0]        have;
	logic signed [5:0] adj_new;
	logic [3:0]        dval;
	logic [MAGW+3:0]   m10;
	logic              mul_ovf;
	logic [MAGW-1:0]   mul_mag;
	logic [4:0]        div_r;
	logic              div_qb;
	logic [3:0]        div_rem;
	logic [DIVW-1:0]   div_next;
	logic [VALUE_BITS-1:0] mag_ext;
	logic              load;

	// Field values seen by this character (cleared on a new field)
	assign mag_b = cmd.clear ? '0 : mag_q;
	assign neg_b = cmd.clear ? 1'b0 : neg_q;
	assign pt_b  = cmd.clear ? 1'b0 : pt_q;
	assign fc_b  = cmd.clear ? 5'd0 : fc_q;
	assign ovf_b = cmd.clear ? 1'b0 : ovf_q;

	// Pending scaling steps: configured digits minus digits seen after point
	assign have    = pt_b ? fc_b : 5'd0;
	assign adj_new = $signed({2'b00, frac_digits}) - $signed({1'b0, have});

	// Times ten plus digit, saturating
	assign dval    = cmd.digit ? ch[3:0] : 4'd0;
	assign m10     = {1'b0, mag_b, 3'b000} + {3'b000, mag_b, 1'b0} +
		{{MAGW{1'b0}}, dval};
	assign mul_ovf = ovf_b || (m10[MAGW+3:MAGW] != 4'd0);
	assign mul_mag = mul_ovf ? MAG_MAX : m10[MAGW-1:0];

	// Restoring divide by ten, DIV_STEP quotient bits per cycle
	always_comb begin
		div_next = div_q;
		div_rem  = rem_q;
		div_r    = '0;
		div_qb   = 1'b0;
		for (int i = 0; i < DIV_STEP; i++) begin
			div_r    = {div_rem, div_next[DIVW-1]};
			div_qb   = (div_r >= 5'd10);
			div_rem  = div_qb ? 4'(div_r - 5'd10) : div_r[3:0];
			div_next = {div_next[DIVW-2:0], div_qb};
		end
	end

	assign mag_ext = {1'b0, mag_q};
	assign load    = cmd.emit_num || cmd.emit_nan;

	// Field and scaling registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q     <= '0;
			neg_q     <= 1'b0;
			pt_q      <= 1'b0;
			fc_q      <= 5'd0;
			ovf_q     <= 1'b0;
			adj_q     <= 6'sd0;
			div_act_q <= 1'b0;
			dcnt_q    <= '0;
			rem_q     <= 4'd0;
			div_q     <= '0;
		end else if (cmd.scale_en) begin
			if (div_act_q) begin
				div_q  <= div_next;
				rem_q  <= div_rem;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == DCW'(DIV_CHUNKS - 1)) begin
					div_act_q <= 1'b0;
					mag_q     <= div_next[MAGW-1:0];
					adj_q     <= adj_q + 6'sd1;
				end
			end else if (!adj_q[5] && (adj_q != 6'sd0)) begin
				mag_q <= mul_mag;
				ovf_q <= mul_ovf;
				adj_q <= adj_q - 6'sd1;
			end else if (adj_q[5]) begin
				// Dividing a saturated or zero magnitude changes nothing
				if (ovf_q || (mag_q == '0)) begin
					adj_q <= 6'sd0;
				end else begin
					div_act_q <= 1'b1;
					dcnt_q    <= '0;
					rem_q     <= 4'd0;
					div_q     <= DIVW'(mag_q);
				end
			end
		end else begin
			mag_q <= cmd.digit ? mul_mag : mag_b;
			ovf_q <= cmd.digit ? mul_ovf : ovf_b;
			neg_q <= neg_b || cmd.neg;
			pt_q  <= pt_b || cmd.point;
			if (cmd.point) begin
				fc_q <= 5'd0;
			end else if (cmd.digit && pt_b && (fc_b != 5'd31)) begin
				fc_q <= fc_b + 5'd1;
			end else begin
				fc_q <= fc_b;
			end
			if (cmd.finish) begin
				adj_q <= adj_new;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ST_OK;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (cmd.emit_nan) begin
				out_value_q  <= {1'b0, MAG_MAX};
				out_status_q <= ST_NAN;
			end else begin
				out_value_q  <= neg_q ? ('0 - mag_ext) : mag_ext;
				out_status_q <= ovf_q ? ST_OVF : ST_OK;
			end
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.scale_done = (adj_q == 6'sd0) && !div_act_q;
	assign sts.out_free   = !out_valid_q || res_ready;

	assign res_valid  = out_valid_q;
	assign res_value  = out_value_q;
	assign res_status = out_status_q;

endmodule

// ----- hw/rtl/nav_ascii_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// nav_ascii_to_fixed_point: navigation ASCII field to signed fixed-point
// The ending character starts the scaling: times-ten steps or divide-by-ten
// steps in chunks of eight quotient bits, where divides stop early on a
// zero or saturated magnitude; the result then goes to the result register.
// A NaN field skips the scaling and loads its result directly.
// Throughput: one character per cycle while parsing, input waits while
// scaling and for a free result register. Reset clears all state and config.
// ----------------------------------------------------------------------------
module nav_ascii_to_fixed_point
	import na2f_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	na2f_char_if.sink         chars,
	na2f_res_if.source        results,
	input  logic              cfg_we,
	input  logic [FRAC_W-1:0] cfg_wdata
);

	localparam logic [VALUE_BITS-1:0] SAT_POS = {1'b0, {(VALUE_BITS - 1){1'b1}}};

	logic [FRAC_W-1:0] frac_q;
	cmd_t              cmd;
	sts_t              sts;

	// Fractional-digits register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= '0;
		end else if (cfg_we) begin
			frac_q <= cfg_wdata;
		end
	end

	// Parser and sequencer
	na2f_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.ch        (chars.ch),
		.start_req (chars.start_req),
		.in_ready  (chars.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Accumulator, scaler and result register
	na2f_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.frac_digits (frac_q),
		.ch          (chars.ch),
		.res_ready   (results.ready),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (results.valid),
		.res_value   (results.value),
		.res_status  (results.status)
	);

`ifndef SYNTHESIS
	// Result register is only loaded when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_num || cmd.emit_nan) |-> sts.out_free)
		else $error("result loaded over a pending transaction");

	// Only one kind of result at a time
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_num && cmd.emit_nan))
		else $error("numeric and NaN result together");

	// A NaN load shows up as a NaN result
	a_nan_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_nan |=> (results.valid && (results.status == ST_NAN) &&
		(results.value == SAT_POS)))
		else $error("NaN result mangled");

	// Saturated results carry the full-scale magnitude
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.status == ST_OVF)) |->
		((results.value == SAT_POS) || (results.value == ('0 - SAT_POS))))
		else $error("overflow result not saturated");
`endif

endmodule
